// ===== hw/rtl/dcm_pkg.sv =====
// Package for the digital carrier modulator: sizes, register and mode codes,
// and the quarter-wave cosine table built at elaboration. No dependencies.
package dcm_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int TAB_N       = 1 << TABLE_ADDR_BITS;
    localparam int COS_W       = SAMPLE_BITS - 1;      // table entries are non-negative
    localparam int GAIN_W      = 15;
    localparam int FREQ_W      = 32;
    localparam int OFFSET_W    = 16;
    localparam int SAMPLE_W    = SAMPLE_BITS + 1;      // sum of two terms
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint HALF_Q30    = ONE_Q30 / 64'sd2;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint COS_MAX     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

    // Horner divisors (2n-1)*(2n) of the cosine series, n = 1..9
    localparam longint HORNER_D1 = 64'sd2;
    localparam longint HORNER_D2 = 64'sd12;
    localparam longint HORNER_D3 = 64'sd30;
    localparam longint HORNER_D4 = 64'sd56;
    localparam longint HORNER_D5 = 64'sd90;
    localparam longint HORNER_D6 = 64'sd132;
    localparam longint HORNER_D7 = 64'sd182;
    localparam longint HORNER_D8 = 64'sd240;
    localparam longint HORNER_D9 = 64'sd306;

    typedef enum logic [1:0] {
        MODE_ASK  = 2'd0,
        MODE_FSK  = 2'd1,
        MODE_BPSK = 2'd2,
        MODE_QPSK = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_FREQ_WORD_A = 3'd1,
        REG_FREQ_WORD_B = 3'd2,
        REG_PHASE_OFF_A = 3'd3,
        REG_PHASE_OFF_B = 3'd4,
        REG_GAIN_A      = 3'd5,
        REG_GAIN_B      = 3'd6
    } cfg_index_t;

    typedef logic [COS_W-1:0] cos_word_t;
    typedef cos_word_t cos_table_t [0:TAB_N];

    // cos(pi/2 * k / N) for k in 0..N, Q30 Horner series, rounded half up
    function automatic cos_table_t build_cos_table();
        cos_table_t tab;
        longint a;
        longint x;
        longint r;
        longint v;
        for (int k = 0; k <= TAB_N; k++)
        begin
            // angle is non-negative, so the shift truncates like the divide
            a = (HALF_PI_Q30 * longint'(k)) >>> TABLE_ADDR_BITS;
            x = a * a / ONE_Q30;
            r = ONE_Q30;
            r = ONE_Q30 - (x * r / ONE_Q30) / HORNER_D9;
            r = ONE_Q30 - (x * r / ONE_Q30) / HORNER_D8;
            r = ONE_Q30 - (x * r / ONE_Q30) / HORNER_D7;
            r = ONE_Q30 - (x * r / ONE_Q30) / HORNER_D6;
            r = ONE_Q30 - (x * r / ONE_Q30) / HORNER_D5;
            r = ONE_Q30 - (x * r / ONE_Q30) / HORNER_D4;
            r = ONE_Q30 - (x * r / ONE_Q30) / HORNER_D3;
            r = ONE_Q30 - (x * r / ONE_Q30) / HORNER_D2;
            r = ONE_Q30 - (x * r / ONE_Q30) / HORNER_D1;
            if (r < 0)
            begin
                r = 0;
            end
            v = (r * (64'sd1 <<< (SAMPLE_BITS - 1)) + HALF_Q30) / ONE_Q30;
            if (v > COS_MAX)
            begin
                v = COS_MAX;
            end
            tab[k] = COS_W'(v);
        end
        return tab;
    endfunction

    localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

// ===== hw/rtl/digital_carrier_modulator_unit.sv =====
// Digital carrier modulator (ASK, FSK, BPSK, QPSK) with two phase accumulators.
// Four register stages (input, table read, products, output) carry each
// accepted item to out_valid. Throughput: one item per clock when the consumer
// does not stall; each stage advances on its own, so bubbles close up under stall.
// Reset (rst_n, async, active low): accumulators zero, mode ASK, words and
// offsets zero, gains 32767, pipeline empty. Uses dcm_pkg.
module digital_carrier_modulator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dcm_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input item channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                data_bit,
    input  logic                                quad_bit,
    // result item channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dcm_pkg::SAMPLE_W-1:0] sample
);
    import dcm_pkg::*;

    localparam int IDX_LO = PHASE_BITS - TABLE_ADDR_BITS - 2;

    // ------------------------------------------------------------------
    // Configuration registers. The port is always ready; an index past
    // the list is dropped.
    // ------------------------------------------------------------------
    mode_t               mode_reg;
    logic [FREQ_W-1:0]   freq_word_a_reg;
    logic [FREQ_W-1:0]   freq_word_b_reg;
    logic [OFFSET_W-1:0] phase_off_a_reg;
    logic [OFFSET_W-1:0] phase_off_b_reg;
    logic [GAIN_W-1:0]   gain_a_reg;
    logic [GAIN_W-1:0]   gain_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_ASK;
            freq_word_a_reg <= '0;
            freq_word_b_reg <= '0;
            phase_off_a_reg <= '0;
            phase_off_b_reg <= '0;
            gain_a_reg      <= '1;
            gain_b_reg      <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MODE:        mode_reg        <= mode_t'(cfg_data[1:0]);
                REG_FREQ_WORD_A: freq_word_a_reg <= cfg_data[FREQ_W-1:0];
                REG_FREQ_WORD_B: freq_word_b_reg <= cfg_data[FREQ_W-1:0];
                REG_PHASE_OFF_A: phase_off_a_reg <= cfg_data[OFFSET_W-1:0];
                REG_PHASE_OFF_B: phase_off_b_reg <= cfg_data[OFFSET_W-1:0];
                REG_GAIN_A:      gain_a_reg      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_B:      gain_b_reg      <= cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: a stage loads when it is empty or the stage
    // after it moves on.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic out_ready;
    logic accept;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign accept    = in_valid && s1_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Phase accumulators: advance on every accepted item, in every mode.
    // The sample uses the values held before the advance.
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] phase_acc_a_reg;
    logic [PHASE_BITS-1:0] phase_acc_b_reg;
    logic [PHASE_BITS-1:0] phase_acc_a_next;
    logic [PHASE_BITS-1:0] phase_acc_b_next;

    assign phase_acc_a_next = phase_acc_a_reg + PHASE_BITS'(freq_word_a_reg);
    assign phase_acc_b_next = phase_acc_b_reg + PHASE_BITS'(freq_word_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_a_reg <= '0;
            phase_acc_b_reg <= '0;
        end
        else if (accept)
        begin
            phase_acc_a_reg <= phase_acc_a_next;
            phase_acc_b_reg <= phase_acc_b_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick the carrier phase, split it into quadrant and table
    // index. BPSK with bit one adds a half turn, which flips the top
    // quadrant bit only. QPSK needs cos and sin of carrier A; sin sits one
    // quadrant back at the same index, so one index serves both terms.
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0]      phase_a;
    logic [PHASE_BITS-1:0]      phase_b;
    logic [PHASE_BITS-1:0]      phase_sel;
    logic                       sel_b;
    logic [1:0]                 quad_in;
    logic                       en_cos_in;
    logic                       en_sin_in;

    logic [1:0]                 s1_quad_reg;
    logic [TABLE_ADDR_BITS-1:0] s1_idx_reg;
    logic                       s1_sel_b_reg;
    logic                       s1_en_cos_reg;
    logic                       s1_en_sin_reg;

    assign phase_a = phase_acc_a_reg
                   + (PHASE_BITS'(phase_off_a_reg) << (PHASE_BITS - OFFSET_W));
    assign phase_b = phase_acc_b_reg
                   + (PHASE_BITS'(phase_off_b_reg) << (PHASE_BITS - OFFSET_W));

    always_comb
    begin
        sel_b     = (mode_reg == MODE_FSK) && data_bit;
        phase_sel = sel_b ? phase_b : phase_a;
        quad_in   = phase_sel[PHASE_BITS-1 -: 2];
        if ((mode_reg == MODE_BPSK) && data_bit)
        begin
            quad_in = quad_in ^ 2'b10;
        end
        // ASK gates by the bit; QPSK takes each term by its own bit
        en_cos_in = ((mode_reg == MODE_ASK) || (mode_reg == MODE_QPSK)) ? data_bit : 1'b1;
        en_sin_in = (mode_reg == MODE_QPSK) && quad_bit;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_quad_reg   <= quad_in;
            s1_idx_reg    <= phase_sel[IDX_LO +: TABLE_ADDR_BITS];
            s1_sel_b_reg  <= sel_b;
            s1_en_cos_reg <= en_cos_in;
            s1_en_sin_reg <= en_sin_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: table read at the index and at its mirror N - index.
    // ------------------------------------------------------------------
    logic [TABLE_ADDR_BITS:0] mirror_idx;
    cos_word_t                s2_t_fwd_reg;
    cos_word_t                s2_t_rev_reg;
    logic [1:0]               s2_quad_reg;
    logic                     s2_sel_b_reg;
    logic                     s2_en_cos_reg;
    logic                     s2_en_sin_reg;

    assign mirror_idx = (TABLE_ADDR_BITS + 1)'(TAB_N) - {1'b0, s1_idx_reg};

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_t_fwd_reg  <= COS_TABLE[s1_idx_reg];
            s2_t_rev_reg  <= COS_TABLE[mirror_idx];
            s2_quad_reg   <= s1_quad_reg;
            s2_sel_b_reg  <= s1_sel_b_reg;
            s2_en_cos_reg <= s1_en_cos_reg;
            s2_en_sin_reg <= s1_en_sin_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sign the table words per quadrant and scale by the gain.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] pos_fwd;
    logic signed [SAMPLE_BITS-1:0] pos_rev;
    logic signed [SAMPLE_BITS-1:0] cos_val;
    logic signed [SAMPLE_BITS-1:0] sin_val;
    logic signed [GAIN_W:0]        gain_sel;
    logic signed [PROD_W-1:0]      s3_prod_cos_reg;
    logic signed [PROD_W-1:0]      s3_prod_sin_reg;
    logic                          s3_en_cos_reg;
    logic                          s3_en_sin_reg;

    assign pos_fwd  = $signed({1'b0, s2_t_fwd_reg});
    assign pos_rev  = $signed({1'b0, s2_t_rev_reg});
    assign gain_sel = $signed({1'b0, (s2_sel_b_reg ? gain_b_reg : gain_a_reg)});

    always_comb
    begin
        case (s2_quad_reg)
            2'd0:
            begin
                cos_val = pos_fwd;
                sin_val = pos_rev;
            end
            2'd1:
            begin
                cos_val = -pos_rev;
                sin_val = pos_fwd;
            end
            2'd2:
            begin
                cos_val = -pos_fwd;
                sin_val = -pos_rev;
            end
            default:
            begin
                cos_val = pos_rev;
                sin_val = -pos_fwd;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_prod_cos_reg <= PROD_W'(cos_val * gain_sel);
            s3_prod_sin_reg <= PROD_W'(sin_val * gain_sel);
            s3_en_cos_reg   <= s2_en_cos_reg;
            s3_en_sin_reg   <= s2_en_sin_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: floor each product to Q.15 (arithmetic shift), drop
    // disabled terms, sum. Hold the sample while the consumer stalls.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]   shift_cos;
    logic signed [PROD_W-1:0]   shift_sin;
    logic signed [SAMPLE_W-1:0] term_cos;
    logic signed [SAMPLE_W-1:0] term_sin;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic signed [SAMPLE_W-1:0] sample_reg;

    assign shift_cos   = s3_prod_cos_reg >>> (SAMPLE_BITS - 1);
    assign shift_sin   = s3_prod_sin_reg >>> (SAMPLE_BITS - 1);
    assign term_cos    = s3_en_cos_reg ? SAMPLE_W'(shift_cos) : '0;
    assign term_sin    = s3_en_sin_reg ? SAMPLE_W'(shift_sin) : '0;
    assign sample_next = term_cos + term_sin;

    always_ff @(posedge clk)
    begin
        if (out_ready && s3_valid_reg)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

`ifndef SYNTHESIS
    // Accumulator A moves by exactly its word on an accepted item.
    a_acc_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> phase_acc_a_reg == $past(phase_acc_a_next))
        else $error("phase accumulator A did not advance by its word");

    // Without an accepted item both accumulators hold.
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_acc_a_reg) && $stable(phase_acc_b_reg))
        else $error("phase accumulator moved without an item");

    // The input side stalls only when every stage holds an item.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    // An item with both terms gated off yields a zero sample.
    a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready && s3_valid_reg && !s3_en_cos_reg && !s3_en_sin_reg
        |=> out_valid_reg && (sample_reg == '0))
        else $error("gated item produced a nonzero sample");
`endif

endmodule
